### sv/dq_pkg.sv
// Types, constants and helpers shared by the detector-angle-to-Q pipeline.
// Used by dq_cell and detector_angle_to_q_sample_top; no dependencies.
package dq_pkg;

  localparam int ROT_W = 34;              // CORDIC x/y width, 30 fractional bits
  localparam int PH_W  = 33;              // residual phase, 2^32 per turn
  localparam logic signed [ROT_W-1:0] CORDIC_X0 = 34'sd652032875;
  localparam logic signed [22:0] Q_MAX = 23'sd4194303;
  localparam logic signed [22:0] Q_MIN = -23'sd4194304;
  localparam logic [19:0] WAVE_RESET = 20'd275036;
  localparam int REG_WAVE = 0;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [PH_W-1:0]  z;
  } rot_t;

  // One word moving down the rotator row: three angles side by side.
  typedef struct packed {
    logic        vld;
    rot_t [2:0]  rot;
    logic [5:0]  quad;
    logic [30:0] wt;
  } cell_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] c;
    logic signed [ROT_W-1:0] s;
  } cs_t;

  function automatic logic signed [PH_W-1:0] atan_turn(input int idx);
    logic signed [PH_W-1:0] v;
    case (idx)
      0:  v = 33'sh020000000;
      1:  v = 33'sh012E4051E;
      2:  v = 33'sh009FB385B;
      3:  v = 33'sh0051111D4;
      4:  v = 33'sh0028B0D43;
      5:  v = 33'sh00145D7E1;
      6:  v = 33'sh000A2F61E;
      7:  v = 33'sh000517C55;
      8:  v = 33'sh00028BE53;
      9:  v = 33'sh000145F2F;
      10: v = 33'sh0000A2F98;
      11: v = 33'sh0000517CC;
      12: v = 33'sh000028BE6;
      13: v = 33'sh0000145F3;
      14: v = 33'sh00000A2FA;
      15: v = 33'sh00000517D;
      16: v = 33'sh0000028BE;
      17: v = 33'sh00000145F;
      18: v = 33'sh000000A30;
      19: v = 33'sh000000518;
      20: v = 33'sh00000028C;
      21: v = 33'sh000000146;
      22: v = 33'sh0000000A3;
      default: v = 33'sh000000051;
    endcase
    return v;
  endfunction

  // Rotate the first-quadrant result back to the full circle.
  function automatic cs_t quad_map(input logic [1:0] q,
                                   input logic signed [ROT_W-1:0] x,
                                   input logic signed [ROT_W-1:0] y);
    cs_t r;
    case (q)
      2'd0: begin r.c = x;  r.s = y;  end
      2'd1: begin r.c = -y; r.s = x;  end
      2'd2: begin r.c = -x; r.s = -y; end
      default: begin r.c = y; r.s = -x; end
    endcase
    return r;
  endfunction

  function automatic logic [22:0] sat23(input logic signed [64:0] v);
    logic [22:0] r;
    if (v > 65'(Q_MAX)) r = Q_MAX;
    else if (v < 65'(Q_MIN)) r = Q_MIN;
    else r = v[22:0];
    return r;
  endfunction

endpackage

### sv/dq_cell.sv
// One CORDIC rotation step for three angles at once, registered.
// Depends on dq_pkg (cell_t, atan_turn).
module dq_cell import dq_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cell_t d_in,
  output cell_t d_out
);

  localparam logic signed [PH_W-1:0] ANG = atan_turn(STAGE);

  cell_t d_nxt;
  cell_t d_r;

  always_comb begin
    d_nxt = d_in;
    for (int j = 0; j < 3; j++) begin
      if (!d_in.rot[j].z[PH_W-1]) begin
        d_nxt.rot[j].x = $signed(d_in.rot[j].x) - ($signed(d_in.rot[j].y) >>> STAGE);
        d_nxt.rot[j].y = $signed(d_in.rot[j].y) + ($signed(d_in.rot[j].x) >>> STAGE);
        d_nxt.rot[j].z = $signed(d_in.rot[j].z) - ANG;
      end else begin
        d_nxt.rot[j].x = $signed(d_in.rot[j].x) + ($signed(d_in.rot[j].y) >>> STAGE);
        d_nxt.rot[j].y = $signed(d_in.rot[j].y) - ($signed(d_in.rot[j].x) >>> STAGE);
        d_nxt.rot[j].z = $signed(d_in.rot[j].z) + ANG;
      end
    end
  end

  // clear only the valid bit on reset; data follows the enable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

### sv/detector_angle_to_q_sample_top.sv
// Channel  | ports                       | word
// in       | in_tvalid/tready/tdata      | angles (3x16) and signal (32)
// out      | out_tvalid/tready/tdata     | q_x, q_y, q_z (23 each), weight (31)
// cfg      | cfg_psel/penable/...        | wave_number at 0
// One word is accepted per cycle unless the output is stalled; the path holds
// CORDIC_STAGES + 7 register stages: rotator row, then multiply, round, rotate.
// Words with a non-positive signal drop out and leave a bubble.
// All stages advance together; a stalled output word holds the whole row.
// rst_n is synchronous; it clears valid bits and reloads wave_number.
module detector_angle_to_q_sample_top import dq_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [15:0] scatter_angle, [31:16] azimuth_angle, [47:32] rotation_angle,
  // [79:48] signal_in
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [22:0] q_x, [45:23] q_y, [68:46] q_z, [99:69] event_weight, [103:100] zero
  output logic [103:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [31:0] KEEP = 32'hFFFFFFFF << (32 - ANGLE_BITS);

  logic en;
  logic [19:0] wave_r;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'(REG_WAVE)) ? {12'd0, wave_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= WAVE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == 1'(REG_WAVE)) begin
      wave_r <= cfg_pwdata[19:0];
    end
  end

  // rotator row
  cell_t chain [CORDIC_STAGES+1];
  cell_t head;
  logic [31:0] ph [3];

  always_comb begin
    head.vld = in_tvalid && en && !in_tdata[79] && (in_tdata[79:48] != 32'd0);
    head.wt  = in_tdata[78:48];
    for (int j = 0; j < 3; j++) begin
      ph[j] = {in_tdata[16*j +: 16], 16'd0} & KEEP;
      head.rot[j].x = CORDIC_X0;
      head.rot[j].y = '0;
      head.rot[j].z = {3'd0, ph[j][29:0]};
      head.quad[2*j +: 2] = ph[j][31:30];
    end
  end

  assign chain[0] = head;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_row
    dq_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .d_in(chain[i]), .d_out(chain[i+1])
    );
  end

  cell_t last;
  assign last = chain[CORDIC_STAGES];

  // stage A: quadrant fold
  cs_t t2_nxt, ph_nxt, rt_nxt;
  logic signed [ROT_W-1:0] c2t_r, s2t_r, cp_r, sp_r, cr_a_r, sr_a_r;
  logic a_vld_r;
  logic [30:0] wt_a_r;
  assign t2_nxt = quad_map(last.quad[1:0], last.rot[0].x, last.rot[0].y);
  assign ph_nxt = quad_map(last.quad[3:2], last.rot[1].x, last.rot[1].y);
  assign rt_nxt = quad_map(last.quad[5:4], last.rot[2].x, last.rot[2].y);

  // stage B: sin*cos, sin*sin, 1 - cos
  logic signed [67:0] p1_nxt, p2_nxt, p1_r, p2_r;
  logic signed [34:0] d_nxt, d_r;
  logic signed [ROT_W-1:0] cr_b_r, sr_b_r;
  logic b_vld_r;
  logic [30:0] wt_b_r;
  assign p1_nxt = s2t_r * cp_r;
  assign p2_nxt = s2t_r * sp_r;
  assign d_nxt  = 35'sd1073741824 - 35'(c2t_r);

  // stage C: round products, (1 - cos) * k
  logic signed [67:0] p1_rnd, p2_rnd;
  logic signed [37:0] a1_nxt, a2_nxt, a1_r, a2_r;
  logic signed [20:0] k_s;
  logic signed [55:0] dk_nxt, dk_r;
  logic signed [ROT_W-1:0] cr_c_r, sr_c_r;
  logic c_vld_r;
  logic [30:0] wt_c_r;
  assign k_s    = $signed({1'b0, wave_r});
  assign p1_rnd = (p1_r + 68'sd536870912) >>> 30;
  assign p2_rnd = (p2_r + 68'sd536870912) >>> 30;
  assign a1_nxt = p1_rnd[37:0];
  assign a2_nxt = p2_rnd[37:0];
  assign dk_nxt = d_r * k_s;

  // stage D: times k, round lz
  logic signed [58:0] ak_nxt, bk_nxt, ak_r, bk_r;
  logic signed [55:0] lz_rnd;
  logic signed [29:0] lz_d_nxt, lz_d_r;
  logic signed [ROT_W-1:0] cr_d_r, sr_d_r;
  logic d_vld_r;
  logic [30:0] wt_d_r;
  assign ak_nxt   = a1_r * k_s;
  assign bk_nxt   = a2_r * k_s;
  assign lz_rnd   = (dk_r + 56'sd33554432) >>> 26;
  assign lz_d_nxt = lz_rnd[29:0];

  // stage E: round and negate lx, ly
  logic signed [58:0] lx_rnd, ly_rnd;
  logic signed [29:0] lx_nxt, ly_nxt, lx_r, ly_r, lz_e_r;
  logic signed [ROT_W-1:0] cr_e_r, sr_e_r;
  logic e_vld_r;
  logic [30:0] wt_e_r;
  assign lx_rnd = -((ak_r + 59'sd33554432) >>> 26);
  assign ly_rnd = -((bk_r + 59'sd33554432) >>> 26);
  assign lx_nxt = lx_rnd[29:0];
  assign ly_nxt = ly_rnd[29:0];

  // stage F: rotation products
  logic signed [63:0] m1_r, m2_r, m3_r, m4_r;
  logic signed [29:0] ly_f_r;
  logic f_vld_r;
  logic [30:0] wt_f_r;

  // stage G: sum, round, saturate into the output register
  logic signed [64:0] sx, sz, qx_w, qz_w, qy_w;
  logic [22:0] qx_nxt, qy_nxt, qz_nxt, qx_r, qy_r, qz_r;
  logic g_vld_r;
  logic [30:0] wt_g_r;
  assign sx     = 65'(m1_r) - 65'(m2_r) + 65'sd8589934592;
  assign sz     = 65'(m3_r) + 65'(m4_r) + 65'sd8589934592;
  assign qx_w   = sx >>> 34;
  assign qz_w   = sz >>> 34;
  assign qy_w   = (65'(ly_f_r) + 65'sd8) >>> 4;
  assign qx_nxt = sat23(qx_w);
  assign qy_nxt = sat23(qy_w);
  assign qz_nxt = sat23(qz_w);

  // advance everything unless the output word is stalled
  assign en        = !g_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
      g_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= last.vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
      g_vld_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2t_r  <= t2_nxt.c;
      s2t_r  <= t2_nxt.s;
      cp_r   <= ph_nxt.c;
      sp_r   <= ph_nxt.s;
      cr_a_r <= rt_nxt.c;
      sr_a_r <= rt_nxt.s;
      wt_a_r <= last.wt;

      p1_r   <= p1_nxt;
      p2_r   <= p2_nxt;
      d_r    <= d_nxt;
      cr_b_r <= cr_a_r;
      sr_b_r <= sr_a_r;
      wt_b_r <= wt_a_r;

      a1_r   <= a1_nxt;
      a2_r   <= a2_nxt;
      dk_r   <= dk_nxt;
      cr_c_r <= cr_b_r;
      sr_c_r <= sr_b_r;
      wt_c_r <= wt_b_r;

      ak_r   <= ak_nxt;
      bk_r   <= bk_nxt;
      lz_d_r <= lz_d_nxt;
      cr_d_r <= cr_c_r;
      sr_d_r <= sr_c_r;
      wt_d_r <= wt_c_r;

      lx_r   <= lx_nxt;
      ly_r   <= ly_nxt;
      lz_e_r <= lz_d_r;
      cr_e_r <= cr_d_r;
      sr_e_r <= sr_d_r;
      wt_e_r <= wt_d_r;

      m1_r   <= cr_e_r * lx_r;
      m2_r   <= sr_e_r * lz_e_r;
      m3_r   <= sr_e_r * lx_r;
      m4_r   <= cr_e_r * lz_e_r;
      ly_f_r <= ly_r;
      wt_f_r <= wt_e_r;

      qx_r   <= qx_nxt;
      qy_r   <= qy_nxt;
      qz_r   <= qz_nxt;
      wt_g_r <= wt_f_r;
    end
  end

  assign out_tvalid = g_vld_r;
  assign out_tdata  = {4'd0, wt_g_r, qz_r, qy_r, qx_r};

endmodule
